FILE: sv/homogeneous_polygon_clipper_assert.svh
// Assertion macros for the polygon clipper
`ifndef HOMOGENEOUS_POLYGON_CLIPPER_ASSERT_SVH
`define HOMOGENEOUS_POLYGON_CLIPPER_ASSERT_SVH
`define HPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define HPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: sv/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg
// Types and constants of the homogeneous polygon clipper.
// ----------------------------------------------------------------------------
package hpc_pkg;
	localparam int MaxVerts = 32;
	localparam int FracBits = 16;
	localparam int IdxW = $clog2(MaxVerts);
	localparam int CntW = $clog2(MaxVerts + 1);
	localparam int AddrW = IdxW + 1;
	localparam int NComp = 7;
	localparam int PlaneW = 3;
	localparam int DistW = 34;
	localparam int QuoW = FracBits + 1;

	localparam logic [PlaneW-1:0] PlaneLeft = 3'd0;
	localparam logic [PlaneW-1:0] PlaneRight = 3'd1;
	localparam logic [PlaneW-1:0] PlaneBottom = 3'd2;
	localparam logic [PlaneW-1:0] PlaneTop = 3'd3;
	localparam logic [PlaneW-1:0] PlaneFar = 3'd4;
	localparam logic [PlaneW-1:0] PlaneNear = 3'd5;

	typedef logic signed [31:0] comp_t;
	typedef comp_t [NComp-1:0] vert_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] norm_z;
		logic signed [31:0] pos_w;
		logic last_vertex;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_nx;
		logic signed [31:0] out_ny;
		logic signed [31:0] out_nz;
		logic signed [31:0] out_w;
		logic last_out;
		logic empty_polygon;
		logic overflowed;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_RD1, ST_RD2, ST_EDGE, ST_DIV, ST_LERP, ST_LERPW, ST_COPY,
		ST_NEXT, ST_ORD, ST_OUT, ST_EMPTY
	} state_t;

	function automatic logic signed [DistW-1:0] plane_dist(logic [PlaneW-1:0] p, vert_t v);
		logic signed [DistW-1:0] x, y, z, w, d;
		x = DistW'(v[0]);
		y = DistW'(v[1]);
		z = DistW'(v[2]);
		w = DistW'(v[6]);
		case (p)
			PlaneLeft: d = x + w;
			PlaneRight: d = w - x;
			PlaneBottom: d = w - y;
			PlaneTop: d = y + w;
			PlaneFar: d = w - z;
			PlaneNear: d = z;
			default: d = '0;
		endcase
		return d;
	endfunction
endpackage

FILE: sv/homogeneous_polygon_clipper.sv
// After the last vertex, up to six clipping passes, one per plane, run before the
// first result is registered in the output buffer.
// Throughput: one vertex per cycle while loading; a crossing edge runs a 17-step
// restoring divider and a serial lerp, one component at a time through LERP and LERPW.
// Results are read back from the vertex memory, registered read.
// arst_n clears counters, flags and state; vertex memory is not cleared.
// ----------------------------------------------------------------------------
// homogeneous_polygon_clipper
// Sutherland-Hodgman clipper over six homogeneous planes, Q16.16.
// ----------------------------------------------------------------------------
`include "homogeneous_polygon_clipper_assert.svh"
module homogeneous_polygon_clipper import hpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);
	vert_t mem [2*MaxVerts];
	logic mem_we;
	logic [AddrW-1:0] mem_wa, mem_ra;
	vert_t mem_wd, rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	state_t st_q, st_d;
	logic [CntW-1:0] n_q, m_q, i_q;
	logic [PlaneW-1:0] plane_q;
	logic bank_q, ovf_q;
	vert_t v1_q, v2_q, res_q;
	logic signed [DistW-1:0] d1_q, d2_q;
	logic [DistW-1:0] den_q, rem_q;
	logic [QuoW-1:0] quo_q;
	logic [4:0] dcnt_q;
	logic [2:0] c_q;
	logic signed [65:0] prod_s1;
	logic wait_q;
	out_item_t obuf_q;
	logic ovalid_q;

	logic [CntW-1:0] i_next;
	logic [IdxW-1:0] idx1, idx2;
	logic signed [DistW-1:0] dv;
	logic in2, in1, acc_in, room;
	assign i_next = (i_q + 1'b1 < n_q) ? i_q + 1'b1 : '0;
	assign idx1 = i_q[IdxW-1:0];
	assign idx2 = i_next[IdxW-1:0];
	assign dv = plane_dist(plane_q, rd_q);
	assign in1 = !d1_q[DistW-1];
	// end vertex distance arrives from memory during the edge state
	assign in2 = (st_q == ST_EDGE) ? !dv[DistW-1] : !d2_q[DistW-1];
	assign acc_in = in_valid && in_ready;
	assign room = m_q < CntW'(MaxVerts);
	assign in_ready = st_q == ST_LOAD;
	assign out_valid = ovalid_q;
	assign out_data = obuf_q;
	logic obuf_free;
	assign obuf_free = !ovalid_q || out_ready;
	logic obuf_load;
	assign obuf_load = obuf_free && ((st_q == ST_OUT && wait_q) || st_q == ST_EMPTY);

	logic signed [32:0] diff;
	logic signed [65:0] rnd;
	logic signed [49:0] q;
	assign diff = 33'(v2_q[c_q]) - 33'(v1_q[c_q]);
	assign rnd = prod_s1 + 66'(1 << (FracBits - 1));
	assign q = rnd[65:FracBits];

	logic [DistW:0] trial;
	assign trial = {rem_q[DistW-2:0], 1'b0} - {1'b0, den_q};

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD: if (acc_in && in_data.last_vertex) st_d = ST_RD1;
			ST_RD1: st_d = ST_RD2;
			ST_RD2: st_d = ST_EDGE;
			ST_EDGE: st_d = (in1 != in2) ? (room ? ST_DIV : (in2 ? ST_COPY : ST_NEXT))
				: (in2 ? ST_COPY : ST_NEXT);
			ST_DIV: if (dcnt_q == 5'(QuoW - 1)) st_d = ST_LERP;
			ST_LERP: st_d = ST_LERPW;
			ST_LERPW: if (c_q == 3'(NComp - 1)) st_d = in2 ? ST_COPY : ST_NEXT;
				else st_d = ST_LERP;
			ST_COPY: st_d = ST_NEXT;
			ST_NEXT: if (i_q + 1'b1 < n_q) st_d = ST_RD1;
				else if (plane_q == PlaneNear) st_d = (m_q == '0) ? ST_EMPTY : ST_ORD;
				else st_d = (m_q == '0) ? ST_EMPTY : ST_RD1;
			ST_ORD: st_d = ST_OUT;
			ST_OUT: if (obuf_free && !wait_q && i_q == n_q) st_d = ST_LOAD;
			ST_EMPTY: if (obuf_free) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = {bank_q, idx1};
		case (st_q)
			ST_LOAD: begin
				mem_we = acc_in && n_q < CntW'(MaxVerts);
				mem_wa = {1'b0, n_q[IdxW-1:0]};
				mem_wd = {in_data.pos_w, in_data.norm_z, in_data.norm_y, in_data.norm_x,
					in_data.pos_z, in_data.pos_y, in_data.pos_x};
				mem_ra = '0;
			end
			ST_RD2: mem_ra = {bank_q, idx2};
			ST_LERPW: begin
				mem_we = c_q == 3'(NComp - 1);
				mem_wa = {!bank_q, m_q[IdxW-1:0]};
				mem_wd = res_q;
				mem_wd[c_q] = comp_t'(33'(v1_q[c_q]) + 33'(q));
			end
			ST_COPY: begin
				mem_we = room;
				mem_wa = {!bank_q, m_q[IdxW-1:0]};
				mem_wd = v2_q;
			end
			ST_ORD, ST_OUT: mem_ra = {bank_q, i_q[IdxW-1:0]};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			n_q <= '0;
			m_q <= '0;
			i_q <= '0;
			plane_q <= '0;
			bank_q <= 1'b0;
			ovf_q <= 1'b0;
			ovalid_q <= 1'b0;
			wait_q <= 1'b0;
			dcnt_q <= '0;
			c_q <= '0;
		end else begin
			st_q <= st_d;
			if (obuf_load) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			case (st_q)
				ST_LOAD: if (acc_in) begin
					if (n_q < CntW'(MaxVerts)) n_q <= n_q + 1'b1;
					else ovf_q <= 1'b1;
					i_q <= '0;
					m_q <= '0;
					plane_q <= PlaneLeft;
					bank_q <= 1'b0;
				end
				ST_EDGE: begin
					if (!room && (in1 != in2 || in2)) ovf_q <= 1'b1;
					if (in1 != in2 && room) begin
						dcnt_q <= '0;
						c_q <= '0;
					end
				end
				ST_DIV: dcnt_q <= dcnt_q + 1'b1;
				ST_LERPW: begin
					c_q <= c_q + 1'b1;
					if (c_q == 3'(NComp - 1)) begin
						m_q <= m_q + 1'b1;
						if (in2 && !(m_q + 1'b1 < CntW'(MaxVerts))) ovf_q <= 1'b1;
					end
				end
				ST_COPY: if (room) m_q <= m_q + 1'b1;
					else ovf_q <= 1'b1;
				ST_NEXT: if (i_q + 1'b1 < n_q) i_q <= i_q + 1'b1;
					else begin
						i_q <= '0;
						n_q <= m_q;
						m_q <= '0;
						bank_q <= !bank_q;
						if (plane_q != PlaneNear) plane_q <= plane_q + 1'b1;
					end
				ST_ORD: begin
					i_q <= i_q + 1'b1;
					wait_q <= 1'b1;
				end
				ST_OUT: if (obuf_free) begin
					if (wait_q) begin
						wait_q <= 1'b0;
						if (i_q == n_q) begin
							n_q <= '0;
							ovf_q <= 1'b0;
							i_q <= '0;
						end
					end else if (i_q != n_q) begin
						i_q <= i_q + 1'b1;
						wait_q <= 1'b1;
					end
				end
				ST_EMPTY: if (obuf_free) begin
					n_q <= '0;
					m_q <= '0;
					i_q <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= diff * $signed({1'b0, quo_q});
		case (st_q)
			ST_RD2: begin
				v1_q <= rd_q;
				d1_q <= dv;
			end
			ST_EDGE: begin
				v2_q <= rd_q;
				d2_q <= dv;
				res_q <= rd_q;
				rem_q <= d1_q[DistW-1] ? DistW'(-d1_q) : DistW'(d1_q);
				den_q <= (d1_q[DistW-1] ? DistW'(-d1_q) : DistW'(d1_q)) +
					(dv[DistW-1] ? DistW'(-dv) : DistW'(dv));
				quo_q <= '0;
			end
			ST_DIV: begin
				if (dcnt_q == '0) begin
					if (rem_q >= den_q) begin
						quo_q <= QuoW'(1);
						rem_q <= rem_q - den_q;
					end
				end else if (!trial[DistW]) begin
					quo_q <= {quo_q[QuoW-2:0], 1'b1};
					rem_q <= trial[DistW-1:0];
				end else begin
					quo_q <= {quo_q[QuoW-2:0], 1'b0};
					rem_q <= {rem_q[DistW-2:0], 1'b0};
				end
			end
			ST_LERPW: res_q[c_q] <= comp_t'(33'(v1_q[c_q]) + 33'(q));
			default: ;
		endcase
		if (obuf_load) begin
			if (st_q == ST_EMPTY) obuf_q <= {{(NComp*32){1'b0}}, 1'b1, 1'b1, ovf_q};
			else obuf_q <= {rd_q[0], rd_q[1], rd_q[2], rd_q[3], rd_q[4], rd_q[5], rd_q[6],
				i_q == n_q, 1'b0, ovf_q};
		end
	end

	`HPC_ASSERT_IMPL(a_in_only_load, in_ready, st_q == ST_LOAD, "ready outside load")
	`HPC_ASSERT_IMPL(a_cnt_max, 1'b1, n_q <= CntW'(MaxVerts), "vertex count overflow")
	`HPC_ASSERT_NEXT(a_empty_last, st_q == ST_EMPTY && obuf_free,
		out_valid && out_data.last_out && out_data.empty_polygon, "empty item malformed")
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives polygons into the homogeneous clipper and compares each clipped
// vertex with a fixed-point Sutherland-Hodgman predictor, with random idling.
// ----------------------------------------------------------------------------
module testbench;
	import hpc_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	homogeneous_polygon_clipper dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	typedef longint vtx_t [NComp];

	vtx_t poly_buf [$];
	logic overflow_seen;
	out_item_t clipped_q [$];
	int errors;
	longint cycles;
	bit hold_off;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd10000000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic longint dist_to(int p, vtx_t v);
		case (p)
			PlaneLeft: return v[0] + v[6];
			PlaneRight: return v[6] - v[0];
			PlaneBottom: return v[6] - v[1];
			PlaneTop: return v[1] + v[6];
			PlaneFar: return v[6] - v[2];
			default: return v[2];
		endcase
	endfunction

	function automatic longint lerp_fx(longint a, longint b, longint u);
		longint prod;
		prod = (b - a) * u + (64'sd1 <<< (FracBits - 1));
		return a + (prod >>> FracBits);
	endfunction

	task automatic clip_polygon();
		vtx_t src [$];
		vtx_t dst [$];
		vtx_t c;
		out_item_t r;
		longint d1, d2, n1, n2, u;
		int n;
		src = poly_buf;
		for (int p = 0; p < 6; p++) begin
			dst = {};
			n = src.size();
			for (int i = 0; i < n; i++) begin
				d1 = dist_to(p, src[i]);
				d2 = dist_to(p, src[(i + 1) % n]);
				if ((d1 >= 0) != (d2 >= 0)) begin
					n1 = d1 < 0 ? -d1 : d1;
					n2 = d2 < 0 ? -d2 : d2;
					u = (n1 <<< FracBits) / (n1 + n2);
					for (int k = 0; k < NComp; k++)
						c[k] = lerp_fx(src[i][k], src[(i + 1) % n][k], u);
					if (dst.size() < MaxVerts) dst.insert(dst.size(), c);
					else overflow_seen = 1'b1;
				end
				if (d2 >= 0) begin
					if (dst.size() < MaxVerts) dst.insert(dst.size(), src[(i + 1) % n]);
					else overflow_seen = 1'b1;
				end
			end
			src = dst;
		end
		if (src.size() == 0) begin
			r = '0;
			r.last_out = 1'b1;
			r.empty_polygon = 1'b1;
			r.overflowed = overflow_seen;
			clipped_q.insert(clipped_q.size(), r);
		end
		for (int k = 0; k < src.size(); k++) begin
			r.out_x = 32'(src[k][0]); r.out_y = 32'(src[k][1]); r.out_z = 32'(src[k][2]);
			r.out_nx = 32'(src[k][3]); r.out_ny = 32'(src[k][4]);
			r.out_nz = 32'(src[k][5]);
			r.out_w = 32'(src[k][6]);
			r.last_out = (k + 1 == src.size());
			r.empty_polygon = 1'b0;
			r.overflowed = overflow_seen;
			clipped_q.insert(clipped_q.size(), r);
		end
		poly_buf = {};
		overflow_seen = 1'b0;
	endtask

	function automatic int gap_len();
		if (no_idle) return 0;
		if ($urandom_range(9) < 6) return 0;
		if ($urandom_range(9) < 8) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic send_vertex(in_item_t item);
		vtx_t v;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		v[0] = longint'(item.pos_x); v[1] = longint'(item.pos_y);
		v[2] = longint'(item.pos_z); v[3] = longint'(item.norm_x);
		v[4] = longint'(item.norm_y); v[5] = longint'(item.norm_z);
		v[6] = longint'(item.pos_w);
		if (poly_buf.size() < MaxVerts) poly_buf.insert(poly_buf.size(), v);
		else overflow_seen = 1'b1;
		if (item.last_vertex) clip_polygon();
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (out_valid && out_ready) begin
			if (clipped_q.size() == 0) begin
				$error("unexpected transfer %h", out_data);
				errors++;
			end else begin
				e = clipped_q.pop_front();
				if (out_data.out_x !== e.out_x) begin
					$error("out_x exp %h got %h", e.out_x, out_data.out_x); errors++; end
				if (out_data.out_y !== e.out_y) begin
					$error("out_y exp %h got %h", e.out_y, out_data.out_y); errors++; end
				if (out_data.out_z !== e.out_z) begin
					$error("out_z exp %h got %h", e.out_z, out_data.out_z); errors++; end
				if (out_data.out_nx !== e.out_nx) begin
					$error("out_nx exp %h got %h", e.out_nx, out_data.out_nx); errors++; end
				if (out_data.out_ny !== e.out_ny) begin
					$error("out_ny exp %h got %h", e.out_ny, out_data.out_ny); errors++; end
				if (out_data.out_nz !== e.out_nz) begin
					$error("out_nz exp %h got %h", e.out_nz, out_data.out_nz); errors++; end
				if (out_data.out_w !== e.out_w) begin
					$error("out_w exp %h got %h", e.out_w, out_data.out_w); errors++; end
				if (out_data.last_out !== e.last_out) begin
					$error("last_out exp %b got %b", e.last_out, out_data.last_out); errors++; end
				if (out_data.empty_polygon !== e.empty_polygon) begin
					$error("empty_polygon exp %b got %b", e.empty_polygon,
						out_data.empty_polygon); errors++; end
				if (out_data.overflowed !== e.overflowed) begin
					$error("overflowed exp %b got %b", e.overflowed, out_data.overflowed);
					errors++; end
			end
		end
	end

	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g == 0) out_ready <= 1'b1;
			else begin
				out_ready <= 1'b0;
				repeat (g - 1) @(posedge clk);
			end
		end
	end

	function automatic logic signed [31:0] rand_comp(int scale);
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2 * scale)) - scale;
			default: return ($signed($urandom_range(2 * scale)) - scale) <<< 12;
		endcase
	endfunction

	function automatic in_item_t mk_vertex(int scale, logic last, logic signed [31:0] w);
		in_item_t it;
		it.pos_x = rand_comp(scale); it.pos_y = rand_comp(scale);
		it.pos_z = rand_comp(scale);
		it.norm_x = $urandom; it.norm_y = $urandom; it.norm_z = $urandom;
		it.pos_w = w;
		it.last_vertex = last;
		return it;
	endfunction

	task automatic send_polygon(int n, int scale);
		for (int i = 0; i < n; i++)
			send_vertex(mk_vertex(scale, i == n - 1,
				$urandom_range(3) == 0 ? $urandom : ($urandom_range(scale) <<< 12)));
	endtask

	task automatic test_directed();
		in_item_t it;
		it = '0;
		it.pos_w = 32'sh0001_0000; it.last_vertex = 1'b1;
		send_vertex(it);
		it = '0; it.pos_x = 32'sh7fff_ffff; it.pos_w = 32'sh0001_0000; it.last_vertex = 1'b1;
		send_vertex(it);
		it = '0; it.pos_x = 32'sh8000_0000; it.pos_y = 32'sh7fff_ffff;
		it.pos_z = 32'sh8000_0000; it.norm_x = 32'sh7fff_ffff; it.norm_y = 32'sh8000_0000;
		it.norm_z = '1; it.pos_w = 32'sh7fff_ffff; send_vertex(it);
		it.pos_x = 32'sh7fff_ffff; it.pos_z = 32'sh7fff_ffff; it.norm_x = 32'sh8000_0000;
		it.pos_w = 32'sh8000_0000; send_vertex(it);
		it.pos_y = 32'sh8000_0000; it.pos_w = 32'sh0000_8000; it.last_vertex = 1'b1;
		send_vertex(it);
		for (int p = 0; p < 6; p++) begin
			for (int i = 0; i < 3; i++) begin
				it = '0;
				it.pos_w = 32'sh0001_0000;
				it.pos_z = 32'sh0000_8000;
				it.norm_x = i <<< 16;
				if (i == 0) begin
					case (p)
						0: it.pos_x = -32'sh0003_0000;
						1: it.pos_x = 32'sh0003_0000;
						2: it.pos_y = 32'sh0003_0000;
						3: it.pos_y = -32'sh0003_0000;
						4: it.pos_z = 32'sh0003_0000;
						default: it.pos_z = -32'sh0003_0000;
					endcase
				end else if (i == 1) it.pos_x = 32'sh0000_4000;
				else it.pos_y = 32'sh0000_4000;
				it.last_vertex = (i == 2);
				send_vertex(it);
			end
		end
	endtask

	task automatic test_overflow();
		for (int i = 0; i < 40; i++) begin
			in_item_t it;
			it = '0;
			it.pos_x = $signed(i) <<< 14; it.pos_y = ((i % 2) ? 32'sh0003_0000 : 0);
			it.pos_z = 32'sh0000_8000; it.pos_w = 32'sh0001_0000;
			it.last_vertex = (i == 39);
			send_vertex(it);
		end
		for (int i = 0; i < 32; i++) begin
			in_item_t it;
			it = '0;
			it.pos_x = (i % 2) ? 32'sh0002_0000 : -32'sh0000_8000;
			it.pos_y = $signed(i) <<< 11;
			it.pos_z = 32'sh0000_8000; it.pos_w = 32'sh0001_0000;
			it.last_vertex = (i == 31);
			send_vertex(it);
		end
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		no_idle = 1'b1;
		repeat (8) send_polygon(4, 4096);
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 280) begin
			n = ($urandom_range(15) == 0) ? $urandom_range(34, 8) : $urandom_range(6, 1);
			send_polygon(n, ($urandom_range(1)) ? 65536 : 4096);
			sent += n;
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_off = 1'b0;
		no_idle = 1'b0;
		overflow_seen = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		while (clipped_q.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0 && clipped_q.size() == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+sv
sv/hpc_pkg.sv
sv/homogeneous_polygon_clipper.sv
tb/testbench.sv
